/* design/psi_pkg.sv */
// Package for the pointer speed and intensity block.
// Holds the datapath command codes, the control and status structs and fixed constants.
// Depends on nothing; psi_if, psi_dp, psi_ctrl and the top level use it by scoped names.
`timescale 1ns / 1ps

package psi_pkg;

    localparam int SPEED_W = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX    = 4'd3;

    localparam logic [15:0] RST_SENS = 16'd32768;
    localparam logic [15:0] RST_MIN  = 16'd2048;
    localparam logic [15:0] RST_MAX  = 16'd6144;

    localparam logic [31:0] GAP_MAX = 32'd999;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 24'hFFFFFF;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam logic [9:0] DEN_THOUSAND = 10'd1000;
    localparam logic [4:0] POW_TOP_BIT = 5'd16;

    // Reciprocals give exact floor division by 10 and by 125 over the operand ranges used.
    localparam logic [27:0] SMOOTH_RECIP = 28'd214748365;
    localparam logic [23:0] FACT_RECIP = 24'd8589935;
    localparam logic [SPEED_W-1:0] FACT_SAT = 24'd256000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQUARE,
        OP_SQRT_DIST,
        OP_DIV_INST,
        OP_DIV_SMOOTH,
        OP_SMOOTH,
        OP_DIV_FACT,
        OP_FACT,
        OP_POW_MUL,
        OP_SQRT_R,
        OP_POW_ROOT,
        OP_INTENS,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic update;
        logic done;
        logic enable;
        logic f_zero;
        logic f_one;
        logic k_zero;
    } t_stat;

endpackage

/* design/psi_if.sv */
// Handshake interfaces for the input, result and configuration channels.
// Depends on psi_pkg for the configuration widths.
`timescale 1ns / 1ps

interface psi_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0] time_ms;
    modport source (output valid, pos_x, pos_y, time_ms, input ready);
    modport sink (input valid, pos_x, pos_y, time_ms, output ready);
endinterface

interface psi_out_if;
    logic valid;
    logic ready;
    logic [23:0] smoothed_speed_out;
    logic [15:0] intensity;
    modport source (output valid, smoothed_speed_out, intensity, input ready);
    modport sink (input valid, smoothed_speed_out, intensity, output ready);
endinterface

interface psi_cfg_if;
    logic valid;
    logic ready;
    logic [psi_pkg::CFG_IDX_W-1:0] index;
    logic [psi_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/psi_sqrt.sv */
// Iterative integer square root, one result bit per cycle, 64-bit radicand.
// Standalone unit used by psi_dp.
`timescale 1ns / 1ps

module psi_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    always_comb begin
        rem_sh = {r_rem, r_rad[63:62]};
        trial = {2'b00, r_root, 2'b01};
        take = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_rad <= i_rad;
                r_rem <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[61:0], 2'b00};
                r_rem <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
                r_root <= {r_root[30:0], take};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* design/psi_div.sv */
// Iterative restoring divider, 36-bit dividend by 10-bit divisor, one bit per cycle.
// Standalone unit used by psi_dp.
`timescale 1ns / 1ps

module psi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [35:0] i_num,
    input  logic [9:0]  i_den,
    output logic        o_done,
    output logic [35:0] o_quot
);
    logic [35:0] r_num;
    logic [9:0]  r_den;
    logic [9:0]  r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [10:0] rem_sh;
    logic        take;

    always_comb begin
        rem_sh = {r_rem, r_num[35]};
        take = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end else if (r_busy) begin
                r_rem <= take ? 10'(rem_sh - {1'b0, r_den}) : rem_sh[9:0];
                r_num <= {r_num[34:0], take};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd35) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

/* design/psi_dp.sv */
// Datapath: configuration and tracking registers, squares, speed, factor, power and intensity.
// Depends on psi_pkg, psi_sqrt and psi_div; driven by commands from psi_ctrl.
`timescale 1ns / 1ps

module psi_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psi_pkg::t_cmd        i_cmd,
    output psi_pkg::t_stat       o_stat,
    input  logic                 i_load,
    input  logic signed [15:0]   i_pos_x,
    input  logic signed [15:0]   i_pos_y,
    input  logic [31:0]          i_time_ms,
    input  logic                 i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [23:0]          o_speed,
    output logic [15:0]          o_intensity
);
    logic        r_en;
    logic [15:0] r_sens;
    logic [15:0] r_min;
    logic [15:0] r_max;

    logic [31:0] r_last_t;
    logic [15:0] r_last_x;
    logic [15:0] r_last_y;
    logic        r_have;
    logic [23:0] r_speed;

    logic               r_upd;
    logic [9:0]         r_gap;
    logic signed [16:0] r_dx;
    logic signed [16:0] r_dy;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic [27:0]        r_snum;
    logic [16:0]        r_f;
    logic [31:0]        r_acc;
    logic               r_acc_one;
    logic [31:0]        r_r;
    logic [4:0]         r_k;
    logic [15:0]        r_int;
    logic [23:0]        r_out_speed;
    logic [15:0]        r_out_int;

    logic [31:0]        gap32;
    logic signed [33:0] sqx_full;
    logic signed [33:0] sqy_full;
    logic [32:0]        sq_sum;
    logic [34:0]        dist_k;
    logic [23:0]        inst;
    logic [27:0]        smooth_num;
    logic [55:0]        smooth_prod;
    logic [46:0]        fact_prod;
    logic               fact_sat;
    logic [16:0]        e_pow;
    logic [63:0]        pow_prod;
    logic [16:0]        p;
    logic               ge;
    logic [15:0]        d;
    logic [32:0]        dprod;
    logic [33:0]        rnd;
    logic [15:0]        term;
    logic [15:0]        n_int;

    logic        sq_start;
    logic [63:0] sq_rad;
    logic        sq_done;
    logic [31:0] sq_root;
    logic        dv_start;
    logic [35:0] dv_num;
    logic [9:0]  dv_den;
    logic        dv_done;
    logic [35:0] dv_quot;

    psi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    psi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quot  (dv_quot)
    );

    always_comb begin
        gap32 = i_time_ms - r_last_t;
        sqx_full = r_dx * r_dx;
        sqy_full = r_dy * r_dy;
        sq_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
        dist_k = 35'(sq_root[24:0]) * 35'(psi_pkg::DEN_THOUSAND);
        inst = (|dv_quot[35:24]) ? psi_pkg::SPEED_MAX : dv_quot[23:0];
        smooth_num = 28'(r_speed) * 28'd7 + 28'(inst) * 28'd3 + 28'd5;
        smooth_prod = 56'(r_snum) * 56'(psi_pkg::SMOOTH_RECIP);
        fact_prod = 47'({r_speed[17:0], 5'd0}) * 47'(psi_pkg::FACT_RECIP);
        fact_sat = r_speed >= psi_pkg::FACT_SAT;
        e_pow = psi_pkg::ONE_Q16 - {1'b0, r_sens};
        pow_prod = 64'(r_acc) * 64'(r_r);

        if (r_f == '0) begin
            p = '0;
        end else if (r_f == psi_pkg::ONE_Q16 || r_acc_one) begin
            p = psi_pkg::ONE_Q16;
        end else begin
            p = {1'b0, r_acc[31:16]};
        end
        ge = r_max >= r_min;
        d = ge ? r_max - r_min : r_min - r_max;
        dprod = 33'(d) * 33'(p);
        rnd = 34'(dprod) + 34'd32768;
        term = rnd[31:16];
        if (!r_en) begin
            n_int = psi_pkg::ONE_Q12;
        end else begin
            n_int = ge ? r_min + term : r_min - term;
        end

        sq_start = 1'b0;
        sq_rad = {r_r, 32'd0};
        dv_start = 1'b0;
        dv_num = {1'b0, dist_k};
        dv_den = r_gap;
        case (i_cmd.op)
            psi_pkg::OP_SQRT_DIST: begin
                sq_start = 1'b1;
                sq_rad = {15'd0, sq_sum, 16'd0};
            end
            psi_pkg::OP_SQRT_R: begin
                sq_start = 1'b1;
            end
            psi_pkg::OP_DIV_INST: begin
                dv_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_sens <= psi_pkg::RST_SENS;
            r_min <= psi_pkg::RST_MIN;
            r_max <= psi_pkg::RST_MAX;
            r_last_t <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_have <= 1'b0;
            r_speed <= '0;
            r_upd <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psi_pkg::CFG_ENABLE: r_en <= i_cfg_data[0];
                    psi_pkg::CFG_SENS:   r_sens <= i_cfg_data;
                    psi_pkg::CFG_MIN:    r_min <= i_cfg_data;
                    psi_pkg::CFG_MAX:    r_max <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_load) begin
                r_upd <= r_have && gap32 != '0 && gap32 <= psi_pkg::GAP_MAX;
                r_last_t <= i_time_ms;
                r_last_x <= i_pos_x;
                r_last_y <= i_pos_y;
                r_have <= 1'b1;
            end
            if (i_cmd.op == psi_pkg::OP_SMOOTH) begin
                r_speed <= smooth_prod[54:31];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gap <= gap32[9:0];
            r_dx <= $signed({i_pos_x[15], i_pos_x}) - $signed({r_last_x[15], r_last_x});
            r_dy <= $signed({i_pos_y[15], i_pos_y}) - $signed({r_last_y[15], r_last_y});
        end
        case (i_cmd.op)
            psi_pkg::OP_SQUARE: begin
                r_sqx <= sqx_full[31:0];
                r_sqy <= sqy_full[31:0];
            end
            psi_pkg::OP_DIV_SMOOTH: begin
                r_snum <= smooth_num;
            end
            psi_pkg::OP_DIV_FACT: begin
                r_f <= fact_sat ? psi_pkg::ONE_Q16 : {1'b0, fact_prod[45:30]};
            end
            psi_pkg::OP_FACT: begin
                r_r <= {r_f[15:0], 16'd0};
                r_acc_one <= 1'b1;
                r_k <= psi_pkg::POW_TOP_BIT;
            end
            psi_pkg::OP_POW_MUL: begin
                if (e_pow[r_k]) begin
                    r_acc <= r_acc_one ? r_r : pow_prod[63:32];
                    r_acc_one <= 1'b0;
                end
            end
            psi_pkg::OP_POW_ROOT: begin
                r_r <= sq_root;
                r_k <= r_k - 5'd1;
            end
            psi_pkg::OP_INTENS: begin
                r_int <= n_int;
            end
            psi_pkg::OP_OUT: begin
                r_out_speed <= r_speed;
                r_out_int <= r_int;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.update = r_upd;
        o_stat.done = sq_done | dv_done;
        o_stat.enable = r_en;
        o_stat.f_zero = r_f == '0;
        o_stat.f_one = r_f == psi_pkg::ONE_Q16;
        o_stat.k_zero = r_k == '0;
    end

    assign o_speed = r_out_speed;
    assign o_intensity = r_out_int;
endmodule

/* design/psi_ctrl.sv */
// Controller state machine that sequences the datapath through one item.
// Depends on psi_pkg; talks to psi_dp by command and status structs.
`timescale 1ns / 1ps

module psi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_out_ready,
    input  psi_pkg::t_stat i_stat,
    output psi_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid
);
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_SQRT_D,
        ST_DIV_I,
        ST_DIV_S,
        ST_SMOOTH,
        ST_DIV_F,
        ST_FACT,
        ST_DECIDE,
        ST_MUL,
        ST_SQRT_R,
        ST_ROOT,
        ST_INT,
        ST_DONE
    } t_state;

    t_state        r_state;
    psi_pkg::t_cmd r_cmd;
    logic          r_in_ready;
    logic          r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cmd.op <= psi_pkg::OP_NONE;
            r_in_ready <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd.op <= psi_pkg::OP_NONE;
            if (r_cmd.op == psi_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_accept) begin
                        r_in_ready <= 1'b0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (i_stat.update) begin
                        r_cmd.op <= psi_pkg::OP_SQUARE;
                        r_state <= ST_SQUARE;
                    end else begin
                        r_cmd.op <= psi_pkg::OP_DIV_FACT;
                        r_state <= ST_DIV_F;
                    end
                end
                ST_SQUARE: begin
                    r_cmd.op <= psi_pkg::OP_SQRT_DIST;
                    r_state <= ST_SQRT_D;
                end
                ST_SQRT_D: begin
                    if (i_stat.done) begin
                        r_cmd.op <= psi_pkg::OP_DIV_INST;
                        r_state <= ST_DIV_I;
                    end
                end
                ST_DIV_I: begin
                    if (i_stat.done) begin
                        r_cmd.op <= psi_pkg::OP_DIV_SMOOTH;
                        r_state <= ST_DIV_S;
                    end
                end
                ST_DIV_S: begin
                    r_cmd.op <= psi_pkg::OP_SMOOTH;
                    r_state <= ST_SMOOTH;
                end
                ST_SMOOTH: begin
                    r_cmd.op <= psi_pkg::OP_DIV_FACT;
                    r_state <= ST_DIV_F;
                end
                ST_DIV_F: begin
                    r_cmd.op <= psi_pkg::OP_FACT;
                    r_state <= ST_FACT;
                end
                ST_FACT: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (!i_stat.enable || i_stat.f_zero || i_stat.f_one) begin
                        r_cmd.op <= psi_pkg::OP_INTENS;
                        r_state <= ST_INT;
                    end else begin
                        r_cmd.op <= psi_pkg::OP_POW_MUL;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (i_stat.k_zero) begin
                        r_cmd.op <= psi_pkg::OP_INTENS;
                        r_state <= ST_INT;
                    end else begin
                        r_cmd.op <= psi_pkg::OP_SQRT_R;
                        r_state <= ST_SQRT_R;
                    end
                end
                ST_SQRT_R: begin
                    if (i_stat.done) begin
                        r_cmd.op <= psi_pkg::OP_POW_ROOT;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    r_cmd.op <= psi_pkg::OP_POW_MUL;
                    r_state <= ST_MUL;
                end
                ST_INT: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_cmd.op <= psi_pkg::OP_OUT;
                        r_in_ready <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cmd = r_cmd;
    assign o_in_ready = r_in_ready;
    assign o_out_valid = r_out_valid;
endmodule

/* design/pointer_speed_intensity.sv */
// Top level of the pointer speed estimator with speed-adaptive intensity.
// Depends on psi_pkg, psi_if, psi_ctrl and psi_dp.
//
//   Channel  Dir  Payload                           Accepted when
//   i_in     in   pos_x, pos_y, time_ms             i_in.valid && i_in.ready
//   o_out    out  smoothed_speed_out, intensity     o_out.valid && o_out.ready
//   i_cfg    in   index, data                       i_cfg.valid && i_cfg.ready
//
// One item at a time, through the check, speed factor and intensity states; the input is
// ready again when the output is issued and the result is valid in the following cycle.
// A speed update adds the squares, the 32-step square root, the 36-step divider and the
// smoothing. With adaptive intensity on and the speed factor strictly between 0 and 1, the
// power adds 16 steps, each bound by the square root, and a last multiply. A result still
// waiting in the output register holds back the end of the next item. Reset is synchronous,
// active low, clears control, config and tracking state, holds both inputs not ready.
`timescale 1ns / 1ps

module pointer_speed_intensity (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psi_in_if.sink     i_in,
    psi_out_if.source  o_out,
    psi_cfg_if.sink    i_cfg
);
    psi_pkg::t_cmd  cmd;
    psi_pkg::t_stat stat;
    logic           in_ready;
    logic           accept;
    logic           cfg_we;

    assign accept = i_in.valid && in_ready;
    assign i_in.ready = in_ready && i_rst_n;
    assign i_cfg.ready = i_rst_n;
    assign cfg_we = i_cfg.valid;

    psi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid)
    );

    psi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_load      (accept),
        .i_pos_x     (i_in.pos_x),
        .i_pos_y     (i_in.pos_y),
        .i_time_ms   (i_in.time_ms),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_speed     (o_out.smoothed_speed_out),
        .o_intensity (o_out.intensity)
    );
endmodule

/* tb/tb.sv */
// Self-checking testbench for pointer_speed_intensity: directed table, then random event streams.
// Depends on psi_pkg and the psi_if interfaces; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [23:0] speed;
        logic [15:0] intens;
    } t_result;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0] t;
        bit has_exp;
        logic [23:0] speed;
        logic [15:0] intens;
    } t_row;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 900;

    logic i_clk;
    logic i_rst_n;
    psi_in_if in_ch();
    psi_out_if out_ch();
    psi_cfg_if cfg_ch();

    pointer_speed_intensity u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    logic cfg_en;
    logic [15:0] cfg_sens, cfg_min, cfg_max;
    logic [31:0] trk_time;
    logic signed [15:0] trk_x, trk_y;
    bit trk_have;
    logic [23:0] trk_speed;

    t_result speed_q[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_updates = 0;
    int cycles = 0;
    int idle_mode = 0;
    logic [31:0] gen_t;
    logic signed [15:0] gen_x, gen_y;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned pow_q16(longint unsigned f, logic [16:0] e);
        longint unsigned acc, r;
        if (f == 0) return 0;
        if (f >= 65536) return 65536;
        acc = 64'd1 << 32;
        r = f << 16;
        for (int k = 16; k >= 0; k--) begin
            if (e[k]) acc = (acc * r) >> 32;
            r = root64(r << 32);
        end
        return acc >> 16;
    endfunction

    function automatic logic [15:0] intensity_from_speed(logic [23:0] sp);
        longint unsigned f, p, d;
        logic [16:0] e;
        if (!cfg_en) return psi_pkg::ONE_Q12;
        f = (longint'(sp) * 256) / 1000;
        if (f > 65536) f = 65536;
        e = 17'd65536 - cfg_sens;
        p = pow_q16(f, e);
        if (cfg_max >= cfg_min) begin
            d = cfg_max - cfg_min;
            return cfg_min + 16'(((d * p) + 32768) >> 16);
        end
        d = cfg_min - cfg_max;
        return cfg_min - 16'(((d * p) + 32768) >> 16);
    endfunction

    function automatic t_result speed_step(logic signed [15:0] x, logic signed [15:0] y,
                                           logic [31:0] t);
        logic [31:0] gap;
        longint dx, dy;
        longint unsigned s, dist_q8, inst;
        t_result res;
        gap = t - trk_time;
        if (trk_have && gap >= 1 && gap <= psi_pkg::GAP_MAX) begin
            dx = longint'(x) - longint'(trk_x);
            dy = longint'(y) - longint'(trk_y);
            s = dx * dx + dy * dy;
            dist_q8 = root64(s << 16);
            inst = (dist_q8 * 1000) / gap;
            if (inst > psi_pkg::SPEED_MAX) inst = psi_pkg::SPEED_MAX;
            trk_speed = 24'((7 * longint'(trk_speed) + 3 * inst + 5) / 10);
            n_updates++;
        end
        trk_time = t;
        trk_x = x;
        trk_y = y;
        trk_have = 1'b1;
        res.speed = trk_speed;
        res.intens = intensity_from_speed(trk_speed);
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    task automatic send_event(logic signed [15:0] x, logic signed [15:0] y, logic [31:0] t,
                              bit has_exp, logic [23:0] sp, logic [15:0] it);
        t_result pred;
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 71 : 0;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.pos_x = x;
        in_ch.pos_y = y;
        in_ch.time_ms = t;
        do @(posedge i_clk); while (!in_ch.ready);
        pred = speed_step(x, y, t);
        if (has_exp) begin
            pred.speed = sp;
            pred.intens = it;
        end
        speed_q.push_back(pred);
        n_items++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (speed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [psi_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            psi_pkg::CFG_ENABLE: cfg_en = val[0];
            psi_pkg::CFG_SENS: cfg_sens = val;
            psi_pkg::CFG_MIN: cfg_min = val;
            psi_pkg::CFG_MAX: cfg_max = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        int pct;
        pct = (idle_mode == 0) ? 71 : (idle_mode == 1) ? 18 : 0;
        out_ch.ready <= ($urandom_range(99) >= pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("pointer_speed_intensity verification failed");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            if (speed_q.size() == 0) begin
                report("unexpected result", out_ch.smoothed_speed_out, -1);
            end else begin
                want = speed_q.pop_front();
                if (out_ch.smoothed_speed_out !== want.speed)
                    report("smoothed_speed_out", out_ch.smoothed_speed_out, want.speed);
                if (out_ch.intensity !== want.intens)
                    report("intensity", out_ch.intensity, want.intens);
            end
        end
    end

    t_row dir_rows[] = '{
        '{16'sd0, 16'sd0, 32'd100, 1, 24'd0, 16'd4096},
        '{16'sd0, 16'sd0, 32'd100, 1, 24'd0, 16'd4096},
        '{16'sd3, 16'sd4, 32'd101, 1, 24'd384000, 16'd4096},
        '{16'sd32767, 16'sd32767, 32'd1100, 0, 24'd0, 16'd0},
        '{-16'sd32768, -16'sd32768, 32'd2100, 0, 24'd0, 16'd0},
        '{16'sd32767, 16'sd32767, 32'd2101, 0, 24'd0, 16'd0},
        '{16'sd32767, 16'sd32767, 32'd2102, 0, 24'd0, 16'd0},
        '{-16'sd32768, 16'sd32767, 32'd50, 0, 24'd0, 16'd0},
        '{16'sd0, 16'sd0, 32'hFFFFFFFF, 0, 24'd0, 16'd0},
        '{16'sd5, 16'sd5, 32'd5, 0, 24'd0, 16'd0},
        '{-16'sd1, -16'sd1, 32'd6, 0, 24'd0, 16'd0},
        '{16'sd100, -16'sd100, 32'd506, 0, 24'd0, 16'd0},
        '{16'sd100, -16'sd100, 32'd507, 0, 24'd0, 16'd0},
        '{-16'sd21846, 16'sd21845, 32'hAAAAAAAA, 0, 24'd0, 16'd0},
        '{16'sd21845, -16'sd21846, 32'hAAAAAAAB, 0, 24'd0, 16'd0}
    };

    initial begin
        logic [15:0] ph_cfg[6][4];
        int per_phase;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.time_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_en = 1'b0;
        cfg_sens = psi_pkg::RST_SENS;
        cfg_min = psi_pkg::RST_MIN;
        cfg_max = psi_pkg::RST_MAX;
        trk_time = '0;
        trk_x = '0;
        trk_y = '0;
        trk_have = 0;
        trk_speed = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_event(dir_rows[i].x, dir_rows[i].y, dir_rows[i].t, dir_rows[i].has_exp,
                       dir_rows[i].speed, dir_rows[i].intens);
        drain();

        ph_cfg[0] = '{16'd1, 16'd32768, 16'd2048, 16'd6144};
        ph_cfg[1] = '{16'd1, 16'd0, 16'd0, 16'd65535};
        ph_cfg[2] = '{16'd1, 16'd65535, 16'd65535, 16'd0};
        ph_cfg[3] = '{16'd0, 16'd1, 16'd4096, 16'd8192};
        ph_cfg[4] = '{16'd1, 16'($urandom), 16'($urandom), 16'($urandom)};
        ph_cfg[5] = '{16'd1, 16'($urandom), 16'($urandom_range(8192)), 16'($urandom)};
        per_phase = 64;
        gen_t = $urandom;
        gen_x = 16'($urandom);
        gen_y = 16'($urandom);

        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = ph / 2;
            for (int r = 0; r < 4; r++)
                write_reg(psi_pkg::CFG_IDX_W'(r), ph_cfg[ph][r]);
            for (int n = 0; n < per_phase; n++) begin
                int pick;
                int span;
                pick = $urandom_range(99);
                if (ph == 2 && n == per_phase / 2) begin
                    @(negedge i_clk);
                    in_ch.valid = 1'b0;
                    while (speed_q.size() != 0) @(posedge i_clk);
                end
                if (pick < 85) begin
                    span = ($urandom_range(9) == 0) ? 4000 : 30;
                    gen_t = gen_t + $urandom_range(999, 1);
                    gen_x = gen_x + 16'($urandom_range(2 * span) - span);
                    gen_y = gen_y + 16'($urandom_range(2 * span) - span);
                end else if (pick < 92) begin
                    gen_t = gen_t + (($urandom_range(1) == 0) ? 32'd0 : $urandom_range(5000, 1000));
                end else begin
                    gen_t = $urandom;
                    gen_x = 16'($urandom);
                    gen_y = 16'($urandom);
                end
                send_event(gen_x, gen_y, gen_t, 0, '0, '0);
            end
            drain();
        end

        $display("Covered %0d items, %0d results, %0d speed updates over 6 register settings,",
                 n_items, n_results, n_updates);
        $display("with sender and receiver stalls in both orders and a stall-free stretch.");
        if (errors == 0) begin
            $display("pointer_speed_intensity verification clean");
        end else begin
            $display("pointer_speed_intensity verification failed");
        end
        $finish;
    end
endmodule
